[hdl/nrbh_pkg.sv]
// nrbh_pkg: shared types and constants for the nearest ray / box hit unit
// no dependencies; imported by nrbh_div and nearest_ray_box_hit_unit
`default_nettype none
package nrbh_pkg;

    // table geometry
    localparam int MAX_BOXES  = 64;
    localparam int SLOT_W     = $clog2(MAX_BOXES);
    localparam int COORD_W    = 32;
    localparam int ENTRY_W    = 6 * COORD_W;

    // fixed point widths
    localparam int BOUND_W    = COORD_W + 2;      // center +- half
    localparam int NUM_W      = COORD_W + 3;      // bound - origin
    localparam int FRAC_W     = 16;
    localparam int DVD_W      = NUM_W + FRAC_W;   // |num| * 65536
    localparam int DIST_W     = 40;
    localparam int T_W        = DIST_W + 2;       // signed, holds +-2^40
    localparam int DIV_STEPS  = DVD_W;
    localparam int CNT_W      = $clog2(DIV_STEPS + 1);

    localparam logic [DIST_W-1:0] DIST_SAT    = {DIST_W{1'b1}};
    localparam logic [DIST_W-1:0] DIST_RESET  = 40'd6553534464;
    localparam logic signed [T_W-1:0] T_INF   = 42'sh100_0000_0000;

    typedef enum logic [1:0] {
        FUNC_STORE  = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_CAST   = 2'd2,
        FUNC_NOP    = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_AXIS,
        ST_DIV_E,
        ST_DIV_X,
        ST_COMB,
        ST_FINAL,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

[hdl/nrbh_ram.sv]
// nrbh_ram: generic single write port / single read port ram, registered read
// no dependencies
`default_nettype none
module nrbh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

[hdl/nrbh_div.sv]
// nrbh_div: bit-serial signed divider, (num * 65536) / den, truncated, saturated
// depends on nrbh_pkg
`default_nettype none
module nrbh_div
    import nrbh_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic signed [NUM_W-1:0]  num,
    input  wire logic signed [COORD_W-1:0] den,
    output      logic                     done,
    output      logic signed [T_W-1:0]    quot
);

    logic                 active_reg, active_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DVD_W-1:0]     dvd_reg, dvd_next;
    logic [COORD_W-1:0]   rem_reg, rem_next;
    logic [COORD_W-1:0]   den_reg, den_next;
    logic                 neg_reg, neg_next;
    logic [NUM_W-1:0]     num_mag;
    logic [COORD_W:0]     rem_sh;
    logic                 q_bit;
    logic [DIST_W-1:0]    mag;

    assign num_mag = num[NUM_W-1] ? (~num + 1'b1) : num;
    assign rem_sh  = {rem_reg, dvd_reg[DVD_W-1]};
    assign q_bit   = (rem_sh >= {1'b0, den_reg});

    // one quotient bit per cycle
    always_comb
    begin
        active_next = active_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        den_next    = den_reg;
        neg_next    = neg_reg;
        if (start)
        begin
            active_next = 1'b1;
            cnt_next    = CNT_W'(DIV_STEPS);
            dvd_next    = {num_mag, {FRAC_W{1'b0}}};
            rem_next    = '0;
            den_next    = den[COORD_W-1] ? (~den + 1'b1) : den;
            neg_next    = num[NUM_W-1] ^ den[COORD_W-1];
        end
        else if (active_reg)
        begin
            rem_next = q_bit ? COORD_W'(rem_sh - {1'b0, den_reg}) : rem_sh[COORD_W-1:0];
            dvd_next = {dvd_reg[DVD_W-2:0], q_bit};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    // saturate magnitude, then apply sign
    assign mag  = (dvd_reg[DVD_W-1:DIST_W] != '0) ? DIST_SAT : dvd_reg[DIST_W-1:0];
    assign quot = neg_reg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
    assign done = done_reg;

endmodule
`default_nettype wire

[hdl/nearest_ray_box_hit_unit.sv]
// nearest_ray_box_hit_unit: top level, command sequencer and slab test datapath
// depends on nrbh_pkg, nrbh_ram, nrbh_div
//
// usage: a command is taken at a rising edge with start high and busy low.
// func selects store box, remove box or cast ray; slot picks the table entry
// for store and remove. box data lives in one ram (center and half extents of
// all three axes side by side); valid marks are flip-flops cleared at reset.
// store, remove and no-op return their all-zero result in the cycle after the
// command, with busy staying low. a cast walks the 64 entries; for a valid
// entry the bit-serial divider finds two slab distances per axis, over up to
// three axes. every result is on hit, hit_slot and hit_distance for one cycle
// with done high; the receiver cannot stall. max_distance is written over
// cfg_valid/cfg_ready while idle and resets to 99999.0. after reset all
// entries are invalid.
`default_nettype none
module nearest_ray_box_hit_unit
    import nrbh_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output      logic                      busy,
    input  wire logic [1:0]                func,
    input  wire logic [SLOT_W-1:0]         slot,
    input  wire logic signed [COORD_W-1:0] pos_x,
    input  wire logic signed [COORD_W-1:0] pos_y,
    input  wire logic signed [COORD_W-1:0] pos_z,
    input  wire logic signed [COORD_W-1:0] vec_x,
    input  wire logic signed [COORD_W-1:0] vec_y,
    input  wire logic signed [COORD_W-1:0] vec_z,
    input  wire logic                      cfg_valid,
    output      logic                      cfg_ready,
    input  wire logic [DIST_W-1:0]         cfg_data,
    output      logic                      done,
    output      logic                      hit,
    output      logic [SLOT_W-1:0]         hit_slot,
    output      logic [DIST_W-1:0]         hit_distance
);

    state_t                    state_reg, state_next;
    logic [MAX_BOXES-1:0]      valid_reg, valid_next;
    logic [DIST_W-1:0]         max_dist_reg, max_dist_next;
    logic [SLOT_W-1:0]         idx_reg, idx_next;
    logic [1:0]                axis_reg, axis_next;
    logic                      done_reg, done_next;
    logic                      hit_reg, hit_next;
    logic [SLOT_W-1:0]         slot_reg, slot_next;
    logic [DIST_W-1:0]         dist_reg, dist_next;
    logic signed [T_W-1:0]     lo_reg, lo_next;
    logic signed [T_W-1:0]     hi_reg, hi_next;
    logic signed [T_W-1:0]     e_reg, e_next;
    logic signed [T_W-1:0]     best_reg, best_next;
    logic [3*COORD_W-1:0]      org_reg, org_next;
    logic [3*COORD_W-1:0]      dir_reg, dir_next;

    logic                      accept;
    logic                      ram_we;
    logic [ENTRY_W-1:0]        entry;
    logic signed [COORD_W-1:0] ax_c, ax_h, ax_o, ax_d;
    logic signed [BOUND_W-1:0] b0, b1, b_min, b_max, o_ext;
    logic signed [NUM_W-1:0]   num0, num1;
    logic                      div_start, div_sel_x, div_done;
    logic signed [NUM_W-1:0]   div_num;
    logic signed [T_W-1:0]     div_quot;
    logic signed [T_W-1:0]     t_en, t_ex;
    logic                      d_zero, in_slab, comb_miss, last_axis, last_box;

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign ram_we    = accept && (func_t'(func) == FUNC_STORE);

    // box table
    nrbh_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_BOXES)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (slot),
        .wr_data ({vec_z, vec_y, vec_x, pos_z, pos_y, pos_x}),
        .rd_addr (idx_reg),
        .rd_data (entry)
    );

    // per-axis operand select
    always_comb
    begin
        case (axis_reg)
            2'd0:
            begin
                ax_c = entry[0*COORD_W +: COORD_W];
                ax_h = entry[3*COORD_W +: COORD_W];
                ax_o = org_reg[0*COORD_W +: COORD_W];
                ax_d = dir_reg[0*COORD_W +: COORD_W];
            end
            2'd1:
            begin
                ax_c = entry[1*COORD_W +: COORD_W];
                ax_h = entry[4*COORD_W +: COORD_W];
                ax_o = org_reg[1*COORD_W +: COORD_W];
                ax_d = dir_reg[1*COORD_W +: COORD_W];
            end
            default:
            begin
                ax_c = entry[2*COORD_W +: COORD_W];
                ax_h = entry[5*COORD_W +: COORD_W];
                ax_o = org_reg[2*COORD_W +: COORD_W];
                ax_d = dir_reg[2*COORD_W +: COORD_W];
            end
        endcase
    end

    // slab bounds and numerators
    assign b0      = {{2{ax_c[COORD_W-1]}}, ax_c} - {{2{ax_h[COORD_W-1]}}, ax_h};
    assign b1      = {{2{ax_c[COORD_W-1]}}, ax_c} + {{2{ax_h[COORD_W-1]}}, ax_h};
    assign o_ext   = {{2{ax_o[COORD_W-1]}}, ax_o};
    assign num0    = {b0[BOUND_W-1], b0} - {o_ext[BOUND_W-1], o_ext};
    assign num1    = {b1[BOUND_W-1], b1} - {o_ext[BOUND_W-1], o_ext};
    assign b_min   = (b0 < b1) ? b0 : b1;
    assign b_max   = (b0 < b1) ? b1 : b0;
    assign d_zero  = (ax_d == '0);
    assign in_slab = (o_ext >= b_min) && (o_ext <= b_max);

    // entry / exit ordering and overlap check
    assign t_en      = (e_reg > div_quot) ? div_quot : e_reg;
    assign t_ex      = (e_reg > div_quot) ? e_reg : div_quot;
    assign comb_miss = (lo_reg > t_ex) || (t_en > hi_reg);
    assign last_axis = (axis_reg == 2'd2);
    assign last_box  = (idx_reg == SLOT_W'(MAX_BOXES - 1));

    assign div_num = div_sel_x ? num1 : num0;

    nrbh_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (ax_d),
        .done  (div_done),
        .quot  (div_quot)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (func_t'(func) == FUNC_CAST))
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                if (valid_reg[idx_reg])
                begin
                    state_next = ST_AXIS;
                end
                else if (last_box)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_AXIS:
            begin
                if (!d_zero)
                begin
                    state_next = ST_DIV_E;
                end
                else if (!in_slab)
                begin
                    state_next = last_box ? ST_DONE : ST_FETCH;
                end
                else if (last_axis)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_DIV_E:
            begin
                if (div_done)
                begin
                    state_next = ST_DIV_X;
                end
            end
            ST_DIV_X:
            begin
                if (div_done)
                begin
                    state_next = ST_COMB;
                end
            end
            ST_COMB:
            begin
                if (comb_miss)
                begin
                    state_next = last_box ? ST_DONE : ST_FETCH;
                end
                else
                begin
                    state_next = last_axis ? ST_FINAL : ST_AXIS;
                end
            end
            ST_FINAL:
            begin
                state_next = last_box ? ST_DONE : ST_FETCH;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and output control
    always_comb
    begin
        valid_next    = valid_reg;
        max_dist_next = max_dist_reg;
        idx_next      = idx_reg;
        axis_next     = axis_reg;
        done_next     = 1'b0;
        hit_next      = hit_reg;
        slot_next     = slot_reg;
        dist_next     = dist_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        e_next        = e_reg;
        best_next     = best_reg;
        org_next      = org_reg;
        dir_next      = dir_reg;
        div_start     = 1'b0;
        div_sel_x     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_valid)
                begin
                    max_dist_next = cfg_data;
                end
                if (accept)
                begin
                    hit_next  = 1'b0;
                    slot_next = '0;
                    dist_next = '0;
                    case (func_t'(func))
                        FUNC_STORE:
                        begin
                            valid_next[slot] = 1'b1;
                            done_next        = 1'b1;
                        end
                        FUNC_REMOVE:
                        begin
                            valid_next[slot] = 1'b0;
                            done_next        = 1'b1;
                        end
                        FUNC_CAST:
                        begin
                            idx_next  = '0;
                            best_next = $signed({2'b00, max_dist_reg});
                            org_next  = {pos_z, pos_y, pos_x};
                            dir_next  = {vec_z, vec_y, vec_x};
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_FETCH:
            begin
                axis_next = 2'd0;
                lo_next   = -T_INF;
                hi_next   = T_INF;
                if (!valid_reg[idx_reg] && !last_box)
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_AXIS:
            begin
                if (!d_zero)
                begin
                    div_start = 1'b1;
                end
                else if (!in_slab)
                begin
                    if (!last_box)
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else if (!last_axis)
                begin
                    axis_next = axis_reg + 1'b1;
                end
            end
            ST_DIV_E:
            begin
                if (div_done)
                begin
                    e_next    = div_quot;
                    div_start = 1'b1;
                    div_sel_x = 1'b1;
                end
            end
            ST_COMB:
            begin
                if (comb_miss)
                begin
                    if (!last_box)
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    if (t_en > lo_reg)
                    begin
                        lo_next = t_en;
                    end
                    if (t_ex < hi_reg)
                    begin
                        hi_next = t_ex;
                    end
                    if (!last_axis)
                    begin
                        axis_next = axis_reg + 1'b1;
                    end
                end
            end
            ST_FINAL:
            begin
                if ((lo_reg > 0) && (lo_reg < best_reg))
                begin
                    best_next = lo_reg;
                    hit_next  = 1'b1;
                    slot_next = idx_reg;
                    dist_next = lo_reg[DIST_W-1:0];
                end
                if (!last_box)
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                done_next = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            max_dist_reg <= DIST_RESET;
            idx_reg      <= '0;
            axis_reg     <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            max_dist_reg <= max_dist_next;
            idx_reg      <= idx_next;
            axis_reg     <= axis_next;
            done_reg     <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        hit_reg  <= hit_next;
        slot_reg <= slot_next;
        dist_reg <= dist_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        e_reg    <= e_next;
        best_reg <= best_next;
        org_reg  <= org_next;
        dir_reg  <= dir_next;
    end

    assign done         = done_reg;
    assign hit          = hit_reg;
    assign hit_slot     = slot_reg;
    assign hit_distance = dist_reg;

endmodule
`default_nettype wire
